FILE: hdl/bts_pkg.sv
// Shared types and constants for the buzzer tone pattern sequencer.
`default_nettype none

package bts_pkg;

  localparam int OP_W      = 2;
  localparam int PERIOD_W  = 16;
  localparam int TONE_W    = 4;
  localparam int SIDX_W    = 4;
  localparam int FREQ_W    = 16;
  localparam int TIME_W    = 24;
  localparam int SCOUNT_W  = 5;
  localparam int REP_W     = 8;
  localparam int DUTY_W    = 7;
  localparam int MODE_W    = 2;
  localparam int ELAPSED_W = 25;

  localparam int APB_AW = 3;
  localparam int APB_DW = 32;

  localparam logic [DUTY_W-1:0] DUTY_RESET = 7'd50;

  // register index, taken from paddr[2]
  localparam logic CFG_IDX_DUTY = 1'b0;

  typedef enum logic [OP_W-1:0] {
    OP_TICK   = 2'd0,
    OP_START  = 2'd1,
    OP_STEP_WR = 2'd2,
    OP_HDR_WR = 2'd3
  } op_t;

  typedef enum logic [MODE_W-1:0] {
    PH_IDLE  = 2'd0,
    PH_SETUP = 2'd1,
    PH_ON    = 2'd2,
    PH_OFF   = 2'd3
  } phase_t;

  typedef struct packed {
    logic [FREQ_W-1:0] freq;
    logic [TIME_W-1:0] on_lim;
    logic [TIME_W-1:0] off_lim;
  } step_entry_t;

  typedef struct packed {
    logic                step_we;
    logic                hdr_we;
    logic [TONE_W-1:0]   tone;
    logic [SIDX_W-1:0]   sidx;
    step_entry_t         entry;
    logic [SCOUNT_W-1:0] step_count;
    logic [REP_W-1:0]    rep;
  } tbl_wr_t;

endpackage

`default_nettype wire

FILE: hdl/bts_item_if.sv
// Input channel: one item per beat.
`default_nettype none

interface bts_item_if
  import bts_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [OP_W-1:0]     op;
  logic [PERIOD_W-1:0] period;
  logic [TONE_W-1:0]   tone;
  logic [SIDX_W-1:0]   step_index;
  logic [FREQ_W-1:0]   step_freq;
  logic [TIME_W-1:0]   on_time;
  logic [TIME_W-1:0]   off_time;
  logic [SCOUNT_W-1:0] step_count;
  logic [REP_W-1:0]    repeat_count;

  modport source (
    output valid, op, period, tone, step_index, step_freq, on_time, off_time,
           step_count, repeat_count,
    input  ready
  );
  modport sink (
    input  valid, op, period, tone, step_index, step_freq, on_time, off_time,
           step_count, repeat_count,
    output ready
  );
endinterface

`default_nettype wire

FILE: hdl/bts_result_if.sv
// Result channel: one result per beat.
`default_nettype none

interface bts_result_if
  import bts_pkg::*;
();
  logic              valid;
  logic              ready;
  logic              pwm_enable;
  logic              sound_gate;
  logic [FREQ_W-1:0] pwm_freq;
  logic [DUTY_W-1:0] duty_out;
  logic [MODE_W-1:0] mode;

  modport source (
    output valid, pwm_enable, sound_gate, pwm_freq, duty_out, mode,
    input  ready
  );
  modport sink (
    input  valid, pwm_enable, sound_gate, pwm_freq, duty_out, mode,
    output ready
  );
endinterface

`default_nettype wire

FILE: hdl/bts_tables.sv
// Step table and tone header memories with registered reads.
`default_nettype none

module bts_tables
  import bts_pkg::*;
#(
  parameter int NUM_TONES = 16,
  parameter int MAX_STEPS = 16,
  localparam int SW = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1,
  localparam int LW = $clog2(MAX_STEPS + 1)
) (
  input  wire logic              clk,
  input  wire tbl_wr_t           wr,
  input  wire logic              rd_en,
  input  wire logic [TONE_W-1:0] rd_tone,
  input  wire logic [SW-1:0]     rd_step_a,
  input  wire logic [SW-1:0]     rd_step_b,
  output step_entry_t            step_a,
  output step_entry_t            step_b,
  output logic [LW-1:0]          hdr_len,
  output logic [REP_W-1:0]       hdr_rep
);

  localparam int DEPTH = NUM_TONES * MAX_STEPS;
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int HW = (NUM_TONES > 1) ? $clog2(NUM_TONES) : 1;

  step_entry_t             step_mem [DEPTH];
  logic [LW+REP_W-1:0]     hdr_mem  [NUM_TONES];

  logic [AW-1:0]   wr_addr;
  logic [AW-1:0]   rd_addr_a;
  logic [AW-1:0]   rd_addr_b;
  logic [HW-1:0]   wr_hdr;
  logic [HW-1:0]   rd_hdr;
  logic [LW-1:0]   wr_len;

  assign wr_addr   = AW'(int'(wr.tone) * MAX_STEPS + int'(wr.sidx));
  assign rd_addr_a = AW'(int'(rd_tone) * MAX_STEPS + int'(rd_step_a));
  assign rd_addr_b = AW'(int'(rd_tone) * MAX_STEPS + int'(rd_step_b));
  assign wr_hdr    = HW'(wr.tone);
  assign rd_hdr    = HW'(rd_tone);

  // step counts above the table row length are stored saturated
  assign wr_len = (int'(wr.step_count) > MAX_STEPS) ? LW'(MAX_STEPS) : LW'(wr.step_count);

  always_ff @(posedge clk) begin
    if (wr.step_we) begin
      step_mem[wr_addr] <= wr.entry;
    end
    if (wr.hdr_we) begin
      hdr_mem[wr_hdr] <= {wr_len, wr.rep};
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      step_a             <= step_mem[rd_addr_a];
      step_b             <= step_mem[rd_addr_b];
      {hdr_len, hdr_rep} <= hdr_mem[rd_hdr];
    end
  end

endmodule

`default_nettype wire

FILE: hdl/buzzer_tone_pattern_sequencer.sv
// Top level: tone pattern sequencer control, result register and APB register.
//
//   channel  dir  beat
//   item     in   op, period, tone, step_index, step_freq, on_time, off_time,
//                 step_count, repeat_count
//   result   out  pwm_enable, sound_gate, pwm_freq, duty_out, mode
//   apb      in   write to pwm_duty (paddr[2] selects the register)
//
// The beat edge launches the step and header memory reads; the edge on which
// the item fires updates the state and loads the result register.
// The next item is taken while a result waits in the result register; a
// stalled result holds the item behind it in the compute stage.
// Reset clears control state only; the tables have no clearing pass.
`default_nettype none

module buzzer_tone_pattern_sequencer
  import bts_pkg::*;
#(
  parameter int NUM_TONES = 16,
  parameter int MAX_STEPS = 16
) (
  input  wire logic              clk,
  input  wire logic              rst,
  bts_item_if.sink               item,
  bts_result_if.source           result,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [APB_AW-1:0] paddr,
  input  wire logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0]      prdata,
  output logic                   pready
);

  localparam int SW = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;
  localparam int PW = $clog2(MAX_STEPS + 1);

  // configuration
  logic [DUTY_W-1:0] duty;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      duty <= DUTY_RESET;
    end else if (psel && penable && pwrite && paddr[2] == CFG_IDX_DUTY) begin
      duty <= pwdata[DUTY_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == CFG_IDX_DUTY) begin
      prdata = {{(APB_DW-DUTY_W){1'b0}}, duty};
    end
  end

  // sequencer state
  phase_t             phase, phase_next;
  logic [ELAPSED_W-1:0] elapsed, elapsed_next;
  logic [PW-1:0]      step_pos, step_pos_next;
  logic [REP_W-1:0]   plays_done, plays_done_next;
  logic [TONE_W-1:0]  active_tone, active_tone_next;
  logic [FREQ_W-1:0]  freq_reg, freq_reg_next;
  logic               pwm_on, pwm_on_next;
  logic               gate_level, gate_level_next;

  // compute stage item
  logic                s1_valid;
  op_t                 s1_op;
  logic [PERIOD_W-1:0] s1_period;
  logic [TONE_W-1:0]   s1_tone;
  logic [SIDX_W-1:0]   s1_sidx;
  logic [FREQ_W-1:0]   s1_freq;
  logic [TIME_W-1:0]   s1_on;
  logic [TIME_W-1:0]   s1_off;
  logic [SCOUNT_W-1:0] s1_scount;
  logic [REP_W-1:0]    s1_rcount;

  // result register
  logic              out_valid;
  logic              out_pwm;
  logic              out_gate;
  logic [FREQ_W-1:0] out_freq;
  logic [DUTY_W-1:0] out_duty;
  logic [MODE_W-1:0] out_mode;

  logic accept;
  logic fire;

  assign item.ready = !s1_valid;
  assign accept     = item.valid && item.ready;
  assign fire       = s1_valid && (!out_valid || result.ready);

  // memory read addresses; step_pos is always below MAX_STEPS between items
  logic [PW-1:0] pos_inc;
  logic [SW-1:0] rd_step_a;
  logic [SW-1:0] rd_step_b;

  assign pos_inc   = step_pos + PW'(1);
  assign rd_step_a = (phase == PH_SETUP) ? '0 : SW'(step_pos);
  assign rd_step_b = (int'(pos_inc) < MAX_STEPS) ? SW'(pos_inc) : '0;

  step_entry_t      step_a;
  step_entry_t      step_b;
  logic [PW-1:0]    hdr_len;
  logic [REP_W-1:0] hdr_rep;
  tbl_wr_t          tbl_wr;

  always_comb begin
    tbl_wr               = '0;
    tbl_wr.tone          = s1_tone;
    tbl_wr.sidx          = s1_sidx;
    tbl_wr.entry.freq    = s1_freq;
    tbl_wr.entry.on_lim  = s1_on;
    tbl_wr.entry.off_lim = s1_off;
    tbl_wr.step_count    = s1_scount;
    tbl_wr.rep           = s1_rcount;
    tbl_wr.step_we       = fire && s1_op == OP_STEP_WR && int'(s1_tone) < NUM_TONES
                           && int'(s1_sidx) < MAX_STEPS;
    tbl_wr.hdr_we        = fire && s1_op == OP_HDR_WR && int'(s1_tone) < NUM_TONES;
  end

  bts_tables #(
    .NUM_TONES(NUM_TONES),
    .MAX_STEPS(MAX_STEPS)
  ) u_tables (
    .clk      (clk),
    .wr       (tbl_wr),
    .rd_en    (accept),
    .rd_tone  (active_tone),
    .rd_step_a(rd_step_a),
    .rd_step_b(rd_step_b),
    .step_a   (step_a),
    .step_b   (step_b),
    .hdr_len  (hdr_len),
    .hdr_rep  (hdr_rep)
  );

  // shared decisions
  logic [ELAPSED_W-1:0] sum;
  logic is_tick;
  logic start_ok;
  logic on_done;
  logic off_done;
  logic more_steps;
  logic last_play;

  assign sum        = elapsed + ELAPSED_W'(s1_period);
  assign is_tick    = s1_op == OP_TICK;
  assign start_ok   = s1_op == OP_START && int'(s1_tone) < NUM_TONES;
  assign on_done    = sum >= ELAPSED_W'(step_a.on_lim);
  assign off_done   = sum >= ELAPSED_W'(step_a.off_lim);
  assign more_steps = pos_inc < hdr_len;
  assign last_play  = plays_done >= hdr_rep;

  // next phase
  always_comb begin
    phase_next = phase;
    if (start_ok) begin
      phase_next = PH_SETUP;
    end else if (is_tick) begin
      case (phase)
        PH_SETUP: phase_next = PH_ON;
        PH_ON: begin
          if (on_done) phase_next = PH_OFF;
        end
        PH_OFF: begin
          if (off_done) begin
            if (more_steps)     phase_next = PH_ON;
            else if (last_play) phase_next = PH_IDLE;
            else                phase_next = PH_SETUP;
          end
        end
        default: phase_next = phase;
      endcase
    end
  end

  // datapath next values
  always_comb begin
    elapsed_next     = elapsed;
    step_pos_next    = step_pos;
    plays_done_next  = plays_done;
    active_tone_next = active_tone;
    freq_reg_next    = freq_reg;
    pwm_on_next      = pwm_on;
    gate_level_next  = gate_level;
    if (start_ok) begin
      active_tone_next = s1_tone;
      elapsed_next     = '0;
      plays_done_next  = '0;
    end else if (is_tick) begin
      case (phase)
        PH_SETUP: begin
          step_pos_next   = '0;
          freq_reg_next   = step_a.freq;
          gate_level_next = 1'b1;
          pwm_on_next     = 1'b1;
        end
        PH_ON: begin
          elapsed_next = sum;
          if (on_done) begin
            elapsed_next    = '0;
            gate_level_next = 1'b0;
          end
        end
        PH_OFF: begin
          elapsed_next = sum;
          if (off_done) begin
            elapsed_next = '0;
            if (more_steps) begin
              step_pos_next   = pos_inc;
              freq_reg_next   = step_b.freq;
              gate_level_next = 1'b1;
              pwm_on_next     = 1'b1;
            end else begin
              step_pos_next = '0;
              if (last_play) begin
                pwm_on_next = 1'b0;
              end else begin
                plays_done_next = plays_done + REP_W'(1);
              end
            end
          end
        end
        default: elapsed_next = elapsed;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      elapsed     <= '0;
      step_pos    <= '0;
      plays_done  <= '0;
      active_tone <= '0;
      freq_reg    <= '0;
      pwm_on      <= 1'b0;
      gate_level  <= 1'b0;
    end else if (fire) begin
      phase       <= phase_next;
      elapsed     <= elapsed_next;
      step_pos    <= step_pos_next;
      plays_done  <= plays_done_next;
      active_tone <= active_tone_next;
      freq_reg    <= freq_reg_next;
      pwm_on      <= pwm_on_next;
      gate_level  <= gate_level_next;
    end
  end

  // compute stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_op     <= op_t'(item.op);
      s1_period <= item.period;
      s1_tone   <= item.tone;
      s1_sidx   <= item.step_index;
      s1_freq   <= item.step_freq;
      s1_on     <= item.on_time;
      s1_off    <= item.off_time;
      s1_scount <= item.step_count;
      s1_rcount <= item.repeat_count;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_pwm  <= pwm_on_next;
      out_gate <= gate_level_next;
      out_freq <= freq_reg_next;
      out_duty <= duty;
      out_mode <= phase_next;
    end
  end

  assign result.valid      = out_valid;
  assign result.pwm_enable = out_pwm;
  assign result.sound_gate = out_gate;
  assign result.pwm_freq   = out_freq;
  assign result.duty_out   = out_duty;
  assign result.mode       = out_mode;

endmodule

`default_nettype wire

FILE: tb/buzzer_tone_pattern_sequencer_test.sv
// Self-checking testbench for the buzzer tone pattern sequencer.
module buzzer_tone_pattern_sequencer_test;
  import bts_pkg::*;

  localparam int NTONES    = 16;
  localparam int NSTEPS    = 16;
  localparam int RUNS      = 5;
  localparam int RUN_ITEMS = 390;

  typedef struct {
    op_t                 op;
    logic [PERIOD_W-1:0] period;
    logic [TONE_W-1:0]   tone;
    logic [SIDX_W-1:0]   step_index;
    logic [FREQ_W-1:0]   step_freq;
    logic [TIME_W-1:0]   on_time;
    logic [TIME_W-1:0]   off_time;
    logic [SCOUNT_W-1:0] step_count;
    logic [REP_W-1:0]    repeat_count;
  } bz_item_t;

  typedef struct packed {
    logic              pwm_enable;
    logic              sound_gate;
    logic [FREQ_W-1:0] pwm_freq;
    logic [DUTY_W-1:0] duty;
    phase_t            mode;
  } bz_out_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  bts_item_if   item_ch();
  bts_result_if result_ch();

  buzzer_tone_pattern_sequencer #(
    .NUM_TONES(NTONES),
    .MAX_STEPS(NSTEPS)
  ) DUT (
    .clk     (clk),
    .rst     (rst),
    .item    (item_ch),
    .result  (result_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #5 clk = ~clk;

  // sequencer state as seen by the predictor
  logic [DUTY_W-1:0]    duty_reg = DUTY_RESET;
  phase_t               ph = PH_IDLE;
  logic [ELAPSED_W-1:0] elapsed = '0;
  logic [4:0]           pos = '0;
  logic [REP_W-1:0]     plays = '0;
  logic [TONE_W-1:0]    cur_tone = '0;
  logic [FREQ_W-1:0]    freq_now = '0;
  logic                 pwm_on = 1'b0;
  logic                 gate = 1'b0;
  step_entry_t          steps [NTONES*NSTEPS];
  logic [SCOUNT_W-1:0]  hdr_len [NTONES];
  logic [REP_W-1:0]     hdr_rep [NTONES];

  // which table entries the stimulus has written so far
  bit step_ok [NTONES*NSTEPS];
  bit hdr_ok [NTONES];

  bz_item_t pending_items[$];
  bz_out_t  expected_outs[$];
  bz_item_t beat_item;
  bz_out_t  want;
  int       n_sent = 0;
  int       n_taken = 0;
  int       n_errors = 0;
  int       gap_pct = 0;
  int       stall_pct = 0;
  int       burst_left = 0;
  int       gap_left = 0;
  int       stall_left = 0;

  function automatic int step_slot();
    return int'(cur_tone) * NSTEPS + ((int'(pos) < NSTEPS) ? int'(pos) : 0);
  endfunction

  function automatic void sound_step();
    freq_now = steps[step_slot()].freq;
    ph = PH_ON;
    gate = 1'b1;
    pwm_on = 1'b1;
  endfunction

  function automatic bz_out_t play_item(input bz_item_t it);
    bz_out_t o;
    case (it.op)
      OP_TICK: begin
        case (ph)
          PH_SETUP: begin
            pos = '0;
            sound_step();
          end
          PH_ON: begin
            elapsed = elapsed + ELAPSED_W'(it.period);
            if (elapsed >= ELAPSED_W'(steps[step_slot()].on_lim)) begin
              elapsed = '0;
              ph = PH_OFF;
              gate = 1'b0;
            end
          end
          PH_OFF: begin
            elapsed = elapsed + ELAPSED_W'(it.period);
            if (elapsed >= ELAPSED_W'(steps[step_slot()].off_lim)) begin
              elapsed = '0;
              pos = pos + 5'd1;
              if (pos < hdr_len[cur_tone]) begin
                sound_step();
              end else begin
                pos = '0;
                if (plays >= hdr_rep[cur_tone]) begin
                  pwm_on = 1'b0;
                  ph = PH_IDLE;
                end else begin
                  plays = plays + REP_W'(1);
                  ph = PH_SETUP;
                end
              end
            end
          end
          default: ;
        endcase
      end
      OP_START: begin
        // gate, enable and frequency hold until the setup tick
        cur_tone = it.tone;
        ph = PH_SETUP;
        elapsed = '0;
        plays = '0;
      end
      OP_STEP_WR: begin
        steps[int'(it.tone) * NSTEPS + int'(it.step_index)] =
          '{freq: it.step_freq, on_lim: it.on_time, off_lim: it.off_time};
      end
      default: begin
        hdr_len[it.tone] = (int'(it.step_count) > NSTEPS) ? SCOUNT_W'(NSTEPS)
                                                            : it.step_count;
        hdr_rep[it.tone] = it.repeat_count;
      end
    endcase
    o.pwm_enable = pwm_on;
    o.sound_gate = gate;
    o.pwm_freq = freq_now;
    o.duty = duty_reg;
    o.mode = ph;
    return o;
  endfunction

  // don't-care fields get random values too
  function automatic bz_item_t rand_item();
    bz_item_t it;
    it.op = OP_TICK;
    it.period = PERIOD_W'($urandom);
    it.tone = TONE_W'($urandom);
    it.step_index = SIDX_W'($urandom);
    it.step_freq = FREQ_W'($urandom);
    it.on_time = TIME_W'($urandom);
    it.off_time = TIME_W'($urandom);
    it.step_count = SCOUNT_W'($urandom);
    it.repeat_count = REP_W'($urandom);
    return it;
  endfunction

  function automatic void queue_tick(input logic [PERIOD_W-1:0] p);
    bz_item_t it = rand_item();
    it.op = OP_TICK;
    it.period = p;
    pending_items.push_back(it);
    n_sent++;
  endfunction

  function automatic void queue_start(input int t);
    bz_item_t it = rand_item();
    it.op = OP_START;
    it.tone = TONE_W'(t);
    pending_items.push_back(it);
    n_sent++;
  endfunction

  function automatic void queue_step(input int t, input int i, input logic [FREQ_W-1:0] f,
                                     input logic [TIME_W-1:0] on_t,
                                     input logic [TIME_W-1:0] off_t);
    bz_item_t it = rand_item();
    it.op = OP_STEP_WR;
    it.tone = TONE_W'(t);
    it.step_index = SIDX_W'(i);
    it.step_freq = f;
    it.on_time = on_t;
    it.off_time = off_t;
    pending_items.push_back(it);
    step_ok[t*NSTEPS+i] = 1'b1;
    n_sent++;
  endfunction

  function automatic void queue_hdr(input int t, input int cnt, input int rep);
    bz_item_t it = rand_item();
    it.op = OP_HDR_WR;
    it.tone = TONE_W'(t);
    it.step_count = SCOUNT_W'(cnt);
    it.repeat_count = REP_W'(rep);
    pending_items.push_back(it);
    hdr_ok[t] = 1'b1;
    n_sent++;
  endfunction

  function automatic logic [PERIOD_W-1:0] pick_period();
    case ($urandom_range(0, 19))
      0: return '1;
      1: return PERIOD_W'($urandom);
      2: return '0;
      default: return PERIOD_W'($urandom_range(1, 120));
    endcase
  endfunction

  function automatic logic [TIME_W-1:0] pick_limit();
    if ($urandom_range(0, 15) == 0) return TIME_W'($urandom);
    return TIME_W'($urandom_range(0, 400));
  endfunction

  function automatic int pick_rep();
    case ($urandom_range(0, 9))
      0: return 255;
      1: return $urandom_range(0, 255);
      default: return $urandom_range(0, 3);
    endcase
  endfunction

  // a full table reads as a count of 16 or anything that saturates to it
  function automatic int pick_count(input int run);
    if (run == NSTEPS) return $urandom_range(NSTEPS, 2**SCOUNT_W - 1);
    return $urandom_range(0, run);
  endfunction

  // number of leading steps of a tone that are written
  function automatic int written_run(input int t);
    int n = 0;
    while (n < NSTEPS && step_ok[t*NSTEPS+n]) n++;
    return n;
  endfunction

  // headers never claim more steps than are written, so no playing tone
  // can reach an unwritten entry
  function automatic void queue_noise();
    int t = $urandom_range(0, NTONES-1);
    int run = written_run(t);
    case ($urandom_range(0, 3))
      0: queue_tick(pick_period());
      1: begin
        if (hdr_ok[t]) queue_start(t);
        else queue_tick(pick_period());
      end
      2: queue_step(t, $urandom_range(0, NSTEPS-1), FREQ_W'($urandom), pick_limit(),
                    pick_limit());
      default: begin
        if (run > 0) queue_hdr(t, pick_count(run), pick_rep());
        else queue_step(t, 0, FREQ_W'($urandom), pick_limit(), pick_limit());
      end
    endcase
  endfunction

  // load a tone, start it and let it run for a while
  function automatic void queue_tune();
    int t = $urandom_range(0, NTONES-1);
    int len = ($urandom_range(0, 9) == 0) ? NSTEPS : $urandom_range(0, 4);
    int ticks = $urandom_range(4, 100);
    for (int i = 0; i < ((len > 0) ? len : 1); i++) begin
      if (!step_ok[t*NSTEPS+i] || $urandom_range(0, 2) == 0)
        queue_step(t, i, FREQ_W'($urandom), pick_limit(), pick_limit());
    end
    queue_hdr(t, (len == NSTEPS) ? pick_count(NSTEPS) : len, pick_rep());
    queue_start(t);
    repeat (ticks) begin
      if ($urandom_range(0, 24) == 0) queue_noise();
      else queue_tick(pick_period());
    end
  endfunction

  task automatic write_duty(input logic [DUTY_W-1:0] v);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {CFG_IDX_DUTY, 2'b00};
    pwdata <= {(APB_DW-DUTY_W)'($urandom), v};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    duty_reg = v;
  endtask

  // item driver: bursts of beats with random gaps
  always @(posedge clk) begin
    if (rst) begin
      item_ch.valid <= 1'b0;
    end else begin
      if (item_ch.valid && item_ch.ready) begin
        expected_outs.push_back(play_item(beat_item));
        n_taken++;
      end
      if (!item_ch.valid || item_ch.ready) begin
        if (gap_left > 0 || pending_items.size() == 0) begin
          if (gap_left > 0) gap_left--;
          item_ch.valid <= 1'b0;
        end else begin
          beat_item = pending_items.pop_front();
          item_ch.op <= beat_item.op;
          item_ch.period <= beat_item.period;
          item_ch.tone <= beat_item.tone;
          item_ch.step_index <= beat_item.step_index;
          item_ch.step_freq <= beat_item.step_freq;
          item_ch.on_time <= beat_item.on_time;
          item_ch.off_time <= beat_item.off_time;
          item_ch.step_count <= beat_item.step_count;
          item_ch.repeat_count <= beat_item.repeat_count;
          item_ch.valid <= 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 30);
            gap_left = ($urandom_range(0, 99) < gap_pct) ? $urandom_range(1, 12) : 0;
          end
        end
      end
    end
  end

  // result monitor and receiver stalls
  always @(posedge clk) begin
    if (rst) begin
      result_ch.ready <= 1'b0;
    end else begin
      if (result_ch.valid && result_ch.ready) begin
        if (expected_outs.size() == 0) begin
          $error("result beat with no expected result");
          n_errors++;
        end else begin
          want = expected_outs.pop_front();
          if (result_ch.pwm_enable !== want.pwm_enable) begin
            $error("pwm_enable: expected %0d, got %0d", want.pwm_enable, result_ch.pwm_enable);
            n_errors++;
          end
          if (result_ch.sound_gate !== want.sound_gate) begin
            $error("sound_gate: expected %0d, got %0d", want.sound_gate, result_ch.sound_gate);
            n_errors++;
          end
          if (result_ch.pwm_freq !== want.pwm_freq) begin
            $error("pwm_freq: expected %0d, got %0d", want.pwm_freq, result_ch.pwm_freq);
            n_errors++;
          end
          if (result_ch.duty_out !== want.duty) begin
            $error("duty_out: expected %0d, got %0d", want.duty, result_ch.duty_out);
            n_errors++;
          end
          if (result_ch.mode !== want.mode) begin
            $error("mode: expected %0d, got %0d", want.mode, result_ch.mode);
            n_errors++;
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        result_ch.ready <= 1'b0;
      end else if ($urandom_range(0, 99) < stall_pct) begin
        stall_left = $urandom_range(0, 9);
        result_ch.ready <= 1'b0;
      end else begin
        result_ch.ready <= 1'b1;
      end
    end
  end

  initial begin
    int target;
    item_ch.valid = 1'b0;
    item_ch.op = OP_TICK;
    item_ch.period = '0;
    item_ch.tone = '0;
    item_ch.step_index = '0;
    item_ch.step_freq = '0;
    item_ch.on_time = '0;
    item_ch.off_time = '0;
    item_ch.step_count = '0;
    item_ch.repeat_count = '0;
    result_ch.ready = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    queue_tick('1);                       // tick while idle
    queue_step(0, 0, '1, '0, '0);
    queue_hdr(0, 0, 0);                   // zero steps: step 0 still plays
    queue_start(0);
    queue_tick('1);                       // setup tick, period not counted
    queue_tick('0);
    queue_tick('0);
    queue_step(15, 0, '0, '1, TIME_W'(1));
    queue_hdr(15, 1, 255);
    queue_start(15);
    queue_tick('0);
    queue_tick('1);
    queue_step(15, 15, 16'h1234, '0, '1); // table writes while playing
    queue_hdr(15, 1, 0);
    queue_start(0);                       // restart while playing
    queue_tick('0);
    queue_tick(PERIOD_W'(1));
    queue_tick(PERIOD_W'(1));

    for (int run = 0; run < RUNS; run++) begin
      if (run > 0) begin
        // duty changes only with the pipeline drained
        while (n_taken != n_sent || expected_outs.size() != 0) @(negedge clk);
        repeat (4) @(posedge clk);
        case (run)
          1: write_duty('0);
          2: write_duty('1);
          3: write_duty(DUTY_W'(100));
          default: write_duty(DUTY_W'($urandom));
        endcase
        @(negedge clk);
      end
      gap_pct = (run == 1 || run == 3) ? 0 : $urandom_range(10, 70);
      stall_pct = (run == 2 || run == 3) ? 0 : $urandom_range(10, 70);
      target = n_sent + RUN_ITEMS;
      while (n_sent < target) begin
        if ($urandom_range(0, 9) < 7) queue_tune();
        else repeat ($urandom_range(1, 6)) queue_noise();
      end
    end

    while (n_taken != n_sent || expected_outs.size() != 0) @(negedge clk);
    repeat (8) @(posedge clk);
    if (n_errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
